[sv/vra_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the value rank assigner.
package vra_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 6;
    localparam int RANK_W        = 7;

    // flipping the sign bit makes unsigned order match signed order
    localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;
    // key of the minimum integer after biasing
    localparam logic [VALUE_W-1:0] MIN_KEY   = '0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_PASS_END,
        S_RD,
        S_SEND
    } state_t;

endpackage

[sv/vra_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
module vra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/value_rank_assigner.sv]
`timescale 1ns / 1ps
// Value rank assigner: loads a list, ranks it by repeated selection, emits the ranks.
//
// Values are loaded one beat per cycle until a beat with s_last; beats past MAX_ITEMS
// elements are dropped, though their last flag still ends the list. Ranking then runs
// up to n selection passes over the n stored elements, each walking the value RAM
// through its one read port with a single 32-bit compare unit; passes stop early once
// the non-minimum elements are all ranked. Minimum-integer elements all get rank 1,
// equal values rank higher the earlier they stand. Results leave in list order, one
// beat at a time, each held until m_ready, last_rank marking the final element. No
// input is taken while ranking or emitting.
module value_rank_assigner #(
    parameter int MAX_ITEMS = vra_pkg::MAX_ITEMS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [vra_pkg::VALUE_W-1:0] s_value,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vra_pkg::POS_W-1:0]   m_position,
    output logic [vra_pkg::RANK_W-1:0]  m_rank,
    output logic                        m_last_rank
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int VW = vra_pkg::VALUE_W;
    localparam int RW = vra_pkg::RANK_W;

    vra_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        r_reg, r_next;
    logic [CW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [AW-1:0]        chk_pos_reg, chk_pos_next;
    logic [VW-1:0]        best_key_reg, best_key_next;
    logic [AW-1:0]        best_pos_reg, best_pos_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        out_idx_reg, out_idx_next;
    logic [MAX_ITEMS-1:0] done_reg, done_next;

    logic          val_we;
    logic [AW-1:0] val_waddr;
    logic [VW-1:0] val_wdata;
    logic [AW-1:0] val_raddr;
    logic [VW-1:0] val_rdata;

    logic          rank_we;
    logic [AW-1:0] rank_waddr;
    logic [RW-1:0] rank_wdata;
    logic [AW-1:0] rank_raddr;
    logic [RW-1:0] rank_rdata;

    logic          full;
    logic [CW-1:0] n_load;
    logic          issue;
    logic          out_last;

    vra_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ITEMS)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    vra_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ITEMS)
    ) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    assign full     = (cnt_reg == CW'(MAX_ITEMS));
    assign n_load   = full ? cnt_reg : cnt_reg + CW'(1);
    assign issue    = (scan_cnt_reg < n_reg);
    assign out_last = ((CW'(out_idx_reg) + CW'(1)) == n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vra_pkg::S_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            r_reg         <= '0;
            scan_cnt_reg  <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_idx_reg   <= '0;
            done_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            r_reg         <= r_next;
            scan_cnt_reg  <= scan_cnt_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            out_idx_reg   <= out_idx_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_pos_reg  <= chk_pos_next;
        best_key_reg <= best_key_next;
        best_pos_reg <= best_pos_next;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        scan_cnt_next  = scan_cnt_reg;
        chk_valid_next = 1'b0;
        chk_pos_next   = scan_cnt_reg[AW-1:0];
        best_key_next  = best_key_reg;
        best_pos_next  = best_pos_reg;
        found_next     = found_reg;
        out_idx_next   = out_idx_reg;
        done_next      = done_reg;

        val_we     = 1'b0;
        val_waddr  = cnt_reg[AW-1:0];
        val_wdata  = s_value ^ vra_pkg::SIGN_BIAS;
        val_raddr  = scan_cnt_reg[AW-1:0];
        rank_we    = 1'b0;
        rank_waddr = chk_pos_reg;
        rank_wdata = RW'(1);
        rank_raddr = out_idx_reg;

        s_ready = 1'b0;
        m_valid = 1'b0;

        unique case (state_reg)
            vra_pkg::S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!full) begin
                        val_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (s_last) begin
                        n_next        = n_load;
                        r_next        = n_load;
                        done_next     = '0;
                        scan_cnt_next = '0;
                        best_key_next = vra_pkg::MIN_KEY;
                        found_next    = 1'b0;
                        state_next    = vra_pkg::S_SCAN;
                    end
                end
            end

            vra_pkg::S_SCAN: begin
                if (issue) begin
                    chk_valid_next = 1'b1;
                    scan_cnt_next  = scan_cnt_reg + CW'(1);
                end
                // compare stage sees the value read in the previous cycle
                if (chk_valid_reg && !done_reg[chk_pos_reg]) begin
                    if (val_rdata == vra_pkg::MIN_KEY) begin
                        rank_we               = 1'b1;
                        done_next[chk_pos_reg] = 1'b1;
                    end else if (val_rdata > best_key_reg) begin
                        best_key_next = val_rdata;
                        best_pos_next = chk_pos_reg;
                        found_next    = 1'b1;
                    end
                end
                if (!issue) begin
                    state_next = vra_pkg::S_PASS_END;
                end
            end

            vra_pkg::S_PASS_END: begin
                if (found_reg) begin
                    rank_we                 = 1'b1;
                    rank_waddr              = best_pos_reg;
                    rank_wdata              = RW'(r_reg);
                    done_next[best_pos_reg] = 1'b1;
                    r_next                  = r_reg - CW'(1);
                end
                if (found_reg && r_reg != CW'(1)) begin
                    scan_cnt_next = '0;
                    best_key_next = vra_pkg::MIN_KEY;
                    found_next    = 1'b0;
                    state_next    = vra_pkg::S_SCAN;
                end else begin
                    // nothing left to select: the rest are minimum values
                    out_idx_next = '0;
                    state_next   = vra_pkg::S_RD;
                end
            end

            vra_pkg::S_RD: begin
                state_next = vra_pkg::S_SEND;
            end

            vra_pkg::S_SEND: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (out_last) begin
                        cnt_next   = '0;
                        state_next = vra_pkg::S_LOAD;
                    end else begin
                        out_idx_next = out_idx_reg + AW'(1);
                        state_next   = vra_pkg::S_RD;
                    end
                end
            end

            default: begin
                state_next = vra_pkg::S_LOAD;
            end
        endcase
    end

    // rank RAM read address holds during S_SEND, so its output stays put
    assign m_position  = vra_pkg::POS_W'(out_idx_reg);
    assign m_rank      = rank_rdata;
    assign m_last_rank = out_last;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_rank_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rank != '0))
        else $error("element left unranked");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= CW'(MAX_ITEMS)) && (n_reg <= CW'(MAX_ITEMS)))
        else $error("element count beyond capacity");

    a_list_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_rank)
            |=> (state_reg == vra_pkg::S_LOAD) && (cnt_reg == '0))
        else $error("store not emptied after final result");

    a_scan_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vra_pkg::S_SCAN) |-> (r_reg != '0) && (n_reg != '0))
        else $error("selection pass with no rank to give");

endmodule

[bench/tb_value_rank_assigner.sv]
`timescale 1ns / 1ps
// Self-checking bench for value_rank_assigner: table lists, then random lists vs a predictor.
module tb_value_rank_assigner;

    localparam int          CLK_HALF    = 10;
    localparam int          RESET_LEN   = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          RAND_ITEMS  = 310;
    localparam int          CALM_AFTER  = 265;
    localparam int          DRAIN_WAIT  = 200;
    localparam int          MAX_SHOWN   = 10;

    localparam int VALUE_W   = vra_pkg::VALUE_W;
    localparam int POS_W     = vra_pkg::POS_W;
    localparam int RANK_W    = vra_pkg::RANK_W;
    localparam int MAX_ITEMS = vra_pkg::MAX_ITEMS_DEF;

    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] rank;
        logic              last_rank;
    } rank_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
        logic                      known;
        logic [RANK_W-1:0]         rank;
    } list_row_t;

    localparam int N_ROWS = 22;

    // known = 1: rank for that element typed in, else taken from the predictor
    list_row_t list_rows [0:N_ROWS-1] = '{
        '{32'sd0,          1'b1, 1'b1, 7'd1},
        '{INT_MIN,         1'b1, 1'b1, 7'd1},
        '{INT_MAX,         1'b1, 1'b1, 7'd1},
        '{INT_MIN,         1'b0, 1'b1, 7'd1},
        '{INT_MAX,         1'b0, 1'b1, 7'd5},
        '{INT_MIN,         1'b0, 1'b1, 7'd1},
        '{-32'sd1,         1'b0, 1'b1, 7'd3},
        '{32'sd0,          1'b1, 1'b1, 7'd4},
        '{32'sd7,          1'b0, 1'b1, 7'd3},
        '{32'sd7,          1'b0, 1'b1, 7'd2},
        '{32'sd7,          1'b1, 1'b1, 7'd1},
        '{32'sd100,        1'b0, 1'b1, 7'd3},
        '{-32'sd100,       1'b0, 1'b1, 7'd1},
        '{32'sd0,          1'b1, 1'b1, 7'd2},
        '{32'sh5555_5555,  1'b0, 1'b1, 7'd2},
        '{32'shaaaa_aaaa,  1'b1, 1'b1, 7'd1},
        '{INT_MIN,         1'b0, 1'b1, 7'd1},
        '{INT_MIN,         1'b1, 1'b1, 7'd1},
        '{-32'sd2,         1'b0, 1'b0, 7'd0},
        '{32'sd9,          1'b0, 1'b0, 7'd0},
        '{-32'sd2,         1'b0, 1'b0, 7'd0},
        '{32'sd9,          1'b1, 1'b0, 7'd0}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic                       s_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [POS_W-1:0]           m_position;
    logic [RANK_W-1:0]          m_rank;
    logic                       m_last_rank;

    // predictor state: biased keys of the list being loaded
    logic [VALUE_W-1:0] list_keys [0:MAX_ITEMS-1];
    logic               typed_ok  [0:MAX_ITEMS-1];
    logic [RANK_W-1:0]  typed_rank [0:MAX_ITEMS-1];
    int                 list_len = 0;

    rank_beat_t  expected_ranks [$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    logic        calm = 1'b0;

    value_rank_assigner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_rank      (m_rank),
        .m_last_rank (m_last_rank)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // selection ranking of the loaded list; queues one beat per element
    function automatic void rank_and_queue();
        logic [RANK_W-1:0]  ranks [0:MAX_ITEMS-1];
        logic [VALUE_W-1:0] best;
        logic               found;
        int                 best_pos;
        int                 r;
        int                 i;
        rank_beat_t         beat;

        for (i = 0; i < MAX_ITEMS; i++) ranks[i] = '0;
        if (list_len == 1) begin
            ranks[0] = RANK_W'(1);
        end else begin
            for (r = list_len; r > 0; r--) begin
                best = vra_pkg::MIN_KEY;
                found = 1'b0;
                best_pos = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_keys[i] == vra_pkg::MIN_KEY && ranks[i] == 0)
                        ranks[i] = RANK_W'(1);
                    // strict compare: earlier element wins a tie
                    if (ranks[i] == 0 && list_keys[i] > best) begin
                        best = list_keys[i];
                        best_pos = i;
                        found = 1'b1;
                    end
                end
                if (found) ranks[best_pos] = r[RANK_W-1:0];
            end
        end
        for (i = 0; i < list_len; i++) begin
            beat.position  = i[POS_W-1:0];
            beat.rank      = typed_ok[i] ? typed_rank[i] : ranks[i];
            beat.last_rank = (i == list_len - 1);
            expected_ranks.push_back(beat);
        end
        list_len = 0;
    endfunction

    function automatic void take_value(input logic signed [VALUE_W-1:0] v,
                                       input logic is_last,
                                       input logic known,
                                       input logic [RANK_W-1:0] kr);
        // past capacity the value is dropped, but last still closes the list
        if (list_len < MAX_ITEMS) begin
            list_keys[list_len]  = v ^ vra_pkg::SIGN_BIAS;
            typed_ok[list_len]   = known;
            typed_rank[list_len] = kr;
            list_len++;
        end
        if (is_last) rank_and_queue();
    endfunction

    task automatic drive_beat(input logic signed [VALUE_W-1:0] v, input logic is_last,
                              input logic known, input logic [RANK_W-1:0] kr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= is_last;
        do @(posedge aclk); while (!s_ready);
        take_value(v, is_last, known, kr);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = INT_MIN;
            1: v = INT_MAX;
            2: v = $signed($urandom_range(0, 6)) - 3;   // dense range, many ties
            3: v = ($urandom_range(0, 1) == 1) ? -32'sd1 : 32'sd0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // result side: random stall bursts until the calm tail
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        rank_beat_t want;
        rank_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_position, m_rank, m_last_rank};
            if (expected_ranks.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected beat: pos %0d rank %0d last %0b",
                             got.position, got.rank, got.last_rank);
            end else begin
                want = expected_ranks.pop_front();
                if (got.position !== want.position || got.rank !== want.rank ||
                    got.last_rank !== want.last_rank) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"mismatch: exp pos %0d rank %0d last %0b, ",
                                  "got pos %0d rank %0d last %0b"},
                                 want.position, want.rank, want.last_rank,
                                 got.position, got.rank, got.last_rank);
                end
            end
        end
    end

    initial begin
        int row;
        int rand_items;
        int list_no;
        int n;
        int k;

        rand_items = 0;
        list_no = 0;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < N_ROWS; row++)
            drive_beat(list_rows[row].value, list_rows[row].is_last,
                       list_rows[row].known, list_rows[row].rank);

        while (rand_items < RAND_ITEMS) begin
            // one full list, one list that overflows the store, the rest short
            if (list_no == 2)      n = MAX_ITEMS;
            else if (list_no == 5) n = MAX_ITEMS + 3;
            else                   n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                if (rand_items >= CALM_AFTER) calm = 1'b1;
                drive_beat(pick_value(), k == n - 1, 1'b0, '0);
                rand_items++;
            end
            list_no++;
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;

        while (expected_ranks.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/vra_pkg.sv
sv/vra_ram.sv
sv/value_rank_assigner.sv
bench/tb_value_rank_assigner.sv
